[rtl/core/vcrd_pkg.sv]
// Shared constants, clock vector types and lane-wise helpers for the
// vector clock race detector core. No dependencies.
package vcrd_pkg;

    localparam int NUM_THREADS = 8;
    localparam int NUM_VARS    = 256;
    localparam int NUM_LOCKS   = 64;
    localparam int CLOCK_WIDTH = 32;

    localparam int MODE_W   = 3;
    localparam int THREAD_W = 3;
    localparam int LOCK_W   = 6;
    localparam int VAR_W    = 8;

    // thread rows first, lock rows after them
    localparam int A_DEPTH = NUM_THREADS + NUM_LOCKS;
    localparam int A_AW    = $clog2(A_DEPTH);
    localparam int B_AW    = $clog2(NUM_VARS);

    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_JOIN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd5;

    typedef logic [CLOCK_WIDTH-1:0] t_entry;
    typedef t_entry [NUM_THREADS-1:0] t_vclk;

    typedef struct packed {
        t_vclk wr;
        t_vclk rd;
    } t_var_row;

    function automatic t_vclk vc_max(t_vclk a, t_vclk b);
        t_vclk m;
        for (int i = 0; i < NUM_THREADS; i++) begin
            m[i] = (a[i] > b[i]) ? a[i] : b[i];
        end
        return m;
    endfunction

    // a <= b in every lane
    function automatic logic vc_le(t_vclk a, t_vclk b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_THREADS; i++) begin
            if (a[i] > b[i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // saturating increment of one lane
    function automatic t_vclk vc_bump(t_vclk a, logic [THREAD_W-1:0] idx);
        t_vclk m;
        m = a;
        if (a[idx] != '1) begin
            m[idx] = a[idx] + t_entry'(1);
        end
        return m;
    endfunction

    function automatic t_vclk vc_thread_init(logic [THREAD_W-1:0] idx);
        t_vclk m;
        m      = '0;
        m[idx] = t_entry'(1);
        return m;
    endfunction

endpackage

[rtl/core/vector_clock_race_detector_core.sv]
// Vector clock race detector: thread and lock clocks in one memory, variable
// read/write clocks in a second; both are read into registers as an item is
// taken. Result is registered on leaving execute (acquire, read, write, no-op)
// or second write-back (release, fork, join: two thread/lock memory writes).
// No new item until idle; a waiting result holds execute or second write-back.
// Reset: per-row valid flags clear at once; unwritten rows read as reset clocks.
module vector_clock_race_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [vcrd_pkg::MODE_W-1:0]   i_mode,
    input  logic [vcrd_pkg::THREAD_W-1:0] i_thread_id,
    input  logic [vcrd_pkg::THREAD_W-1:0] i_other_thread,
    input  logic [vcrd_pkg::LOCK_W-1:0]   i_lock_id,
    input  logic [vcrd_pkg::VAR_W-1:0]    i_var_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_race_found
);
    import vcrd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;

    logic [1:0] r_state, n_state;

    // item registers
    logic [MODE_W-1:0]   r_mode;
    logic [THREAD_W-1:0] r_t, r_u;
    logic [LOCK_W-1:0]   r_lk;
    logic [B_AW-1:0]     r_v;
    logic                r_ok;

    // memories and per-row valid flags
    t_vclk    mem_a [0:A_DEPTH-1];
    t_var_row mem_b [0:NUM_VARS-1];
    logic [A_DEPTH-1:0]  r_va;
    logic [NUM_VARS-1:0] r_vb;

    t_vclk    r_a0_q, r_a1_q;
    t_var_row r_b_q;
    logic     r_a0_vld, r_a1_vld, r_b_vld, r_a1_thr;

    logic r_out_vld, r_race;

    logic            accept, ok_in, fin_ok, out_load, race_n;
    logic [A_AW-1:0] a0_addr, a1_addr;
    logic            a1_is_lock;

    logic            wa_en, wb_en;
    logic [A_AW-1:0] wa_addr;
    t_vclk           wa_data;
    t_var_row        wb_data;

    t_vclk    a0, a1, max01;
    t_var_row bq;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign fin_ok   = !r_out_vld || !i_stall;
    assign o_valid  = r_out_vld;
    assign o_race_found = r_race;

    // decode at accept
    always_comb begin
        ok_in      = 1'b0;
        a1_is_lock = (i_mode == MODE_ACQUIRE) || (i_mode == MODE_RELEASE);
        unique case (i_mode)
            MODE_ACQUIRE, MODE_RELEASE: ok_in = 32'(i_lock_id) < NUM_LOCKS;
            MODE_FORK, MODE_JOIN:       ok_in = 32'(i_other_thread) < NUM_THREADS;
            MODE_READ, MODE_WRITE:      ok_in = 32'(i_var_id) < NUM_VARS;
            default:                    ok_in = 1'b0;
        endcase
        if (!(32'(i_thread_id) < NUM_THREADS)) begin
            ok_in = 1'b0;
        end
        a0_addr = A_AW'(i_thread_id);
        a1_addr = a1_is_lock ? (A_AW'(NUM_THREADS) + A_AW'(i_lock_id))
                             : A_AW'(i_other_thread);
    end

    // memory A: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (wa_en) begin
            mem_a[wa_addr] <= wa_data;
        end
        if (accept) begin
            r_a0_q <= mem_a[a0_addr];
            r_a1_q <= mem_a[a1_addr];
        end
    end

    // memory B: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            mem_b[r_v] <= wb_data;
        end
        if (accept) begin
            r_b_q <= mem_b[B_AW'(i_var_id)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
        end else begin
            if (wa_en) begin
                r_va[wa_addr] <= 1'b1;
            end
            if (wb_en) begin
                r_vb[r_v] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_t      <= i_thread_id;
            r_u      <= i_other_thread;
            r_lk     <= i_lock_id;
            r_v      <= B_AW'(i_var_id);
            r_ok     <= ok_in;
            r_a0_vld <= r_va[a0_addr];
            r_a1_vld <= r_va[a1_addr];
            r_a1_thr <= !a1_is_lock;
            r_b_vld  <= r_vb[B_AW'(i_var_id)];
        end
    end

    // rows never written read as their reset clocks
    always_comb begin
        a0    = r_a0_vld ? r_a0_q : vc_thread_init(r_t);
        a1    = r_a1_vld ? r_a1_q : (r_a1_thr ? vc_thread_init(r_u) : '0);
        bq    = r_b_vld ? r_b_q : '0;
        max01 = vc_max(a0, a1);
    end

    // execute and write back
    always_comb begin
        n_state  = r_state;
        wa_en    = 1'b0;
        wa_addr  = A_AW'(r_t);
        wa_data  = max01;
        wb_en    = 1'b0;
        wb_data  = bq;
        race_n   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_ok) begin
                    unique case (r_mode)
                        MODE_ACQUIRE: begin
                            wa_en = 1'b1;
                        end
                        MODE_RELEASE: begin
                            wa_en   = 1'b1;
                            wa_addr = A_AW'(NUM_THREADS) + A_AW'(r_lk);
                            wa_data = a0;
                        end
                        MODE_FORK: begin
                            wa_en   = 1'b1;
                            wa_addr = A_AW'(r_u);
                        end
                        MODE_JOIN: begin
                            wa_en = 1'b1;
                        end
                        MODE_READ: begin
                            if (vc_le(bq.wr, a0)) begin
                                wb_en      = fin_ok;
                                wb_data.rd = vc_max(bq.rd, a0);
                            end else begin
                                race_n = (bq.rd[r_t] != a0[r_t]);
                            end
                        end
                        MODE_WRITE: begin
                            if (vc_le(bq.wr, a0) && vc_le(bq.rd, a0)) begin
                                wb_en      = fin_ok;
                                wb_data.wr = vc_max(bq.wr, a0);
                            end else begin
                                race_n = (bq.wr[r_t] != a0[r_t]);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (r_ok && (r_mode == MODE_RELEASE || r_mode == MODE_FORK ||
                             r_mode == MODE_JOIN)) begin
                    n_state = S_WR2;
                end else if (fin_ok) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WR2: begin
                // repeat while the result waits: same data, same row
                wa_en = 1'b1;
                if (r_mode == MODE_JOIN) begin
                    wa_addr = A_AW'(r_u);
                    wa_data = vc_bump(a1, r_u);
                end else begin
                    wa_addr = A_AW'(r_t);
                    wa_data = vc_bump(a0, r_t);
                end
                if (fin_ok) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_race <= race_n;
        end
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!wa_en && !wb_en))
        else $error("memory write while idle");

    a_one_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wa_en && wb_en))
        else $error("both memories written in one cycle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execute");

    a_race_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && race_n) |-> (r_ok && (r_mode == MODE_READ || r_mode == MODE_WRITE)))
        else $error("race flagged on a non-access item");

endmodule
